// ===== src/sfp_pkg.sv =====
// Types, constants and arithmetic helpers for the stick frame processor.
`default_nettype none

package sfp_pkg;

   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned SCALED_W  = 13;
   localparam int unsigned DIFF_W    = 14;
   localparam int unsigned CHAN_W    = 11;
   localparam int unsigned LEVEL_W   = 10;
   localparam int unsigned ACC_W     = 19;
   localparam int unsigned ACC_SUM_W = 21;
   localparam int unsigned FRAME_W   = 8;
   localparam int unsigned DUTY_W    = 8;
   localparam int unsigned PAGE_W    = 2;
   localparam int unsigned DZ_W      = 10;
   localparam int unsigned DB_W      = 12;
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [CSR_ADDR_W-1:0] CSR_THROTTLE_DEADZONE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATE_DEADBAND     = 1'b1;

   localparam logic [DZ_W-1:0] DEADZONE_RESET = 10'd150;
   localparam logic [DB_W-1:0] DEADBAND_RESET = 12'd100;

   localparam logic [PAGE_W-1:0] CAL_PAGE = 2'd2;

   localparam int unsigned ACC_MAX   = 500000;
   localparam int unsigned ACC_SCALE = 500;

   // floor(m/11) = (m*SCALE_RECIP) >> SCALE_SHIFT, exact for m < 104857
   localparam int unsigned SCALE_RECIP = 95326;
   localparam int unsigned SCALE_SHIFT = 20;
   // floor(acc/500), exact over the accumulator range
   localparam int unsigned LEVEL_RECIP = 536871;
   localparam int unsigned LEVEL_SHIFT = 28;
   // floor(acc*255/500000), exact over the accumulator range
   localparam longint unsigned DUTY_RECIP = 35046934;
   localparam int unsigned DUTY_SHIFT = 36;

   typedef struct packed {
      logic                calibrate_button;
      logic                page_button;
      logic [SAMPLE_W-1:0] adc_yaw;
      logic [SAMPLE_W-1:0] adc_rate;
      logic [SAMPLE_W-1:0] adc_pitch;
      logic [SAMPLE_W-1:0] adc_roll;
   } raw_frame_type;

   typedef struct packed {
      logic                       calibrate_button;
      logic                       page_button;
      logic signed [SCALED_W-1:0] yaw;
      logic signed [SCALED_W-1:0] rate;
      logic signed [SCALED_W-1:0] pitch;
      logic signed [SCALED_W-1:0] roll;
   } scaled_frame_type;

   typedef struct packed {
      logic [PAGE_W-1:0]        page_now;
      logic [FRAME_W-1:0]       frame_number;
      logic [ACC_W-1:0]         acc;
      logic signed [CHAN_W-1:0] yaw;
      logic signed [CHAN_W-1:0] pitch;
      logic signed [CHAN_W-1:0] roll;
   } chan_frame_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]       throttle_level;
      logic [PAGE_W-1:0]        page_now;
      logic [DUTY_W-1:0]        led_duty;
      logic [FRAME_W-1:0]       frame_number;
      logic signed [CHAN_W-1:0] yaw_out;
      logic [LEVEL_W-1:0]       throttle_out;
      logic signed [CHAN_W-1:0] pitch_out;
      logic signed [CHAN_W-1:0] roll_out;
   } result_type;

   // trunc(((raw - 2048) * 1000) / 550) = trunc((raw - 2048) * 20 / 11)
   function automatic logic signed [SCALED_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] raw);
      logic signed [SCALED_W-1:0] centred;
      logic signed [16:0]         times20;
      logic [15:0]                mag;
      logic [32:0]                prod;
      logic [SCALED_W-1:0]        quot;
      centred = $signed({1'b0, raw}) - 13'sd2048;
      times20 = 17'(centred) * 17'sd20;
      mag     = times20[16] ? 16'(-times20) : 16'(times20);
      prod    = 33'(mag) * 33'(SCALE_RECIP);
      quot    = SCALED_W'(prod >> SCALE_SHIFT);
      return times20[16] ? -$signed(quot) : $signed(quot);
   endfunction

   function automatic logic signed [CHAN_W-1:0] clamp_chan(input logic signed [DIFF_W-1:0] v);
      logic signed [CHAN_W-1:0] res;
      if (v > 14'sd1000) begin
         res = 11'sd1000;
      end else if (v < -14'sd1000) begin
         res = -11'sd1000;
      end else begin
         res = CHAN_W'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/stick_frame_processor.sv =====
// Top level of the stick frame processor: scaling, calibration, throttle and page logic.
`default_nettype none

// One frame in, one result out. A frame passes four register stages (input,
// sample scaling, channel and state update, output), and the output stage offers
// its result; a new frame is taken every cycle while the result side keeps up, and
// stalls only back up as far as the first empty stage. The throttle accumulator,
// offsets, page and sequence number live in the state-update stage, which sees
// one frame per cycle in order unless stalled. The user writes registers through
// the csr_ port only while no frame is in flight; the block does not enforce this.
// Index 0 is the throttle deadzone, index 1 the rate deadband.
module stick_frame_processor #(
   parameter int unsigned PAGE_COUNT = 3
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: adc_roll, adc_pitch, adc_rate, adc_yaw, page_button,
   // calibrate_button, zero padding
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [sfp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: roll_out, pitch_out, throttle_out, yaw_out, frame_number,
   // led_duty, page_now, throttle_level, zero padding
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [sfp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [sfp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [sfp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned PAGE_CNT_W = 3;

   logic [sfp_pkg::DZ_W-1:0]         deadzone_ff;
   logic [sfp_pkg::DB_W-1:0]         deadband_ff;

   logic                             v1_ff, v2_ff, v3_ff, v4_ff;
   logic                             rdy1, rdy2, rdy3, rdy4;

   sfp_pkg::raw_frame_type           raw_ff;
   sfp_pkg::scaled_frame_type        scaled_ff, scaled_in;
   sfp_pkg::chan_frame_type          chan_ff, chan_in;
   sfp_pkg::result_type              result_ff, result_in;

   logic [sfp_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic signed [sfp_pkg::SCALED_W-1:0] roll_off_ff, roll_off_in;
   logic signed [sfp_pkg::SCALED_W-1:0] pitch_off_ff, pitch_off_in;
   logic signed [sfp_pkg::SCALED_W-1:0] yaw_off_ff, yaw_off_in;
   logic [sfp_pkg::FRAME_W-1:0]      frame_ff, frame_in;
   logic [sfp_pkg::PAGE_W-1:0]       page_ff, page_in;
   logic                             page_btn_ff, page_btn_in;
   logic                             cal_btn_ff, cal_btn_in;

   logic                             step2;
   logic signed [sfp_pkg::DIFF_W-1:0]    db_s, rate_s;
   logic signed [sfp_pkg::ACC_SUM_W-1:0] acc_sum;
   logic [PAGE_CNT_W-1:0]            page_inc;
   logic [38:0]                      level_prod;
   logic [44:0]                      duty_prod;
   logic [19:0]                      dz_thresh;
   logic [sfp_pkg::LEVEL_W-1:0]      level;

   // stage readiness: a stage may load when it is empty or being emptied
   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {1'b0, result_ff};
   assign step2      = v2_ff && rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= sfp_pkg::DEADZONE_RESET;
         deadband_ff <= sfp_pkg::DEADBAND_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            sfp_pkg::CSR_THROTTLE_DEADZONE: deadzone_ff <= csr_wdata[sfp_pkg::DZ_W-1:0];
            sfp_pkg::CSR_RATE_DEADBAND:     deadband_ff <= csr_wdata[sfp_pkg::DB_W-1:0];
            default: ;
         endcase
      end
   end

   // sample scaling
   always_comb begin
      scaled_in.roll             = sfp_pkg::scale_sample(raw_ff.adc_roll);
      scaled_in.pitch            = sfp_pkg::scale_sample(raw_ff.adc_pitch);
      scaled_in.rate             = sfp_pkg::scale_sample(raw_ff.adc_rate);
      scaled_in.yaw              = sfp_pkg::scale_sample(raw_ff.adc_yaw);
      scaled_in.page_button      = raw_ff.page_button;
      scaled_in.calibrate_button = raw_ff.calibrate_button;
   end

   // calibration, accumulator and page state
   always_comb begin
      chan_in.roll  = sfp_pkg::clamp_chan(sfp_pkg::DIFF_W'(scaled_ff.roll)
                                          - sfp_pkg::DIFF_W'(roll_off_ff));
      chan_in.pitch = sfp_pkg::clamp_chan(sfp_pkg::DIFF_W'(scaled_ff.pitch)
                                          - sfp_pkg::DIFF_W'(pitch_off_ff));
      chan_in.yaw   = sfp_pkg::clamp_chan(sfp_pkg::DIFF_W'(scaled_ff.yaw)
                                          - sfp_pkg::DIFF_W'(yaw_off_ff));

      db_s    = $signed({2'b00, deadband_ff});
      rate_s  = sfp_pkg::DIFF_W'(scaled_ff.rate);
      acc_sum = $signed({2'b00, acc_ff});
      if (rate_s > db_s || rate_s < -db_s) begin
         acc_sum = acc_sum + sfp_pkg::ACC_SUM_W'(scaled_ff.rate);
      end
      if (acc_sum < 0) begin
         acc_in = '0;
      end else if (acc_sum > sfp_pkg::ACC_SUM_W'(sfp_pkg::ACC_MAX)) begin
         acc_in = sfp_pkg::ACC_W'(sfp_pkg::ACC_MAX);
      end else begin
         acc_in = sfp_pkg::ACC_W'(acc_sum);
      end

      page_inc = PAGE_CNT_W'(page_ff) + 3'd1;
      page_in  = page_ff;
      if (scaled_ff.page_button && !page_btn_ff) begin
         page_in = (page_inc == PAGE_CNT_W'(PAGE_COUNT)) ? '0
                                                        : sfp_pkg::PAGE_W'(page_inc);
      end
      page_btn_in = scaled_ff.page_button;
      cal_btn_in  = scaled_ff.calibrate_button;

      roll_off_in  = roll_off_ff;
      pitch_off_in = pitch_off_ff;
      yaw_off_in   = yaw_off_ff;
      if (scaled_ff.calibrate_button && !cal_btn_ff && page_in == sfp_pkg::CAL_PAGE) begin
         roll_off_in  = scaled_ff.roll;
         pitch_off_in = scaled_ff.pitch;
         yaw_off_in   = scaled_ff.yaw;
      end

      frame_in             = frame_ff + 8'd1;
      chan_in.acc          = acc_in;
      chan_in.frame_number = frame_ff;
      chan_in.page_now     = page_in;
   end

   // throttle level, deadzone and LED duty
   always_comb begin
      level_prod = 39'(chan_ff.acc) * 39'(sfp_pkg::LEVEL_RECIP);
      duty_prod  = 45'(chan_ff.acc) * 45'(sfp_pkg::DUTY_RECIP);
      dz_thresh  = 20'(deadzone_ff) * 20'(sfp_pkg::ACC_SCALE);
      level      = sfp_pkg::LEVEL_W'(level_prod >> sfp_pkg::LEVEL_SHIFT);

      result_in.roll_out       = chan_ff.roll;
      result_in.pitch_out      = chan_ff.pitch;
      result_in.yaw_out        = chan_ff.yaw;
      result_in.throttle_out   = (20'(chan_ff.acc) < dz_thresh) ? '0 : level;
      result_in.frame_number   = chan_ff.frame_number;
      result_in.led_duty       = sfp_pkg::DUTY_W'(duty_prod >> sfp_pkg::DUTY_SHIFT);
      result_in.page_now       = chan_ff.page_now;
      result_in.throttle_level = level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         acc_ff       <= '0;
         roll_off_ff  <= '0;
         pitch_off_ff <= '0;
         yaw_off_ff   <= '0;
         frame_ff     <= '0;
         page_ff      <= '0;
         page_btn_ff  <= 1'b0;
         cal_btn_ff   <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (step2) begin
            acc_ff       <= acc_in;
            roll_off_ff  <= roll_off_in;
            pitch_off_ff <= pitch_off_in;
            yaw_off_ff   <= yaw_off_in;
            frame_ff     <= frame_in;
            page_ff      <= page_in;
            page_btn_ff  <= page_btn_in;
            cal_btn_ff   <= cal_btn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) raw_ff <= req_tdata[$bits(sfp_pkg::raw_frame_type)-1:0];
      if (rdy2 && v1_ff)      scaled_ff <= scaled_in;
      if (step2)              chan_ff <= chan_in;
      if (rdy4 && v3_ff)      result_ff <= result_in;
   end

endmodule

`default_nettype wire
